@@ src/mctb_pkg.sv @@
// package for the multi-channel timer bank: request and result types,
// action and mode codes. no dependencies.
package mctb_pkg;

	localparam logic [2:0] ACT_REGISTER = 3'd0;
	localparam logic [2:0] ACT_REMOVE   = 3'd1;
	localparam logic [2:0] ACT_START    = 3'd2;
	localparam logic [2:0] ACT_STOP     = 3'd3;
	localparam logic [2:0] ACT_TICK     = 3'd4;
	localparam logic [2:0] ACT_POLL     = 3'd5;

	localparam logic [1:0] MODE_ONCE    = 2'd0;
	localparam logic [1:0] MODE_COUNTED = 2'd1;
	localparam logic [1:0] MODE_FOREVER = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  channel;
		logic [1:0]  mode;
		logic [31:0] repeat_count;
		logic [31:0] interval;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic        fired;
		logic [3:0]  fired_channel;
		logic [31:0] tick_count;
		logic        last_of_run;
	} out_item_t;

endpackage

@@ src/mctb_chan_mem.sv @@
// channel record memory: one write port, one read port, registered read data
// that holds while no read is issued. no dependencies.
module mctb_chan_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 98
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/multi_channel_soft_timer_bank_top.sv @@
// multi-channel timer bank top level: request sequencer, flags, tick counter,
// output register. depends on mctb_pkg and mctb_chan_mem.

// A bank of NUM_CHANNELS timers sharing one wrapping TICK_WIDTH-bit tick counter.
// Channel records (mode, repeats, interval, stamp) live in a single-port-read
// memory with registered read data; registered and running flags are flops.
// Register, remove, start, stop, tick and unknown actions read the channel
// record, then write back and load the result; they wait while the output
// register is full. A poll reads one channel per cycle via the memory read port,
// then posts the final result; it stalls if one is due and the output register
// is full. A poll yields one result per firing channel in ascending order, or one
// result with fired low when nothing fires. The next request is taken as soon as
// the sequencer is idle, even while the last result waits in the output register.
module multi_channel_soft_timer_bank_top #(
	parameter int NUM_CHANNELS = 16,
	parameter int TICK_WIDTH   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mctb_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mctb_pkg::out_item_t out_item
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	typedef struct packed {
		logic [1:0]            mode;
		logic [31:0]           reps;
		logic [TICK_WIDTH-1:0] ivl;
		logic [TICK_WIDTH-1:0] stamp;
	} entry_t;

	localparam int EW = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t                  state_q;
	mctb_pkg::in_item_t      req_q;
	logic [CH_W-1:0]         idx_q;
	logic                    pend_vld_q;
	logic [CH_W-1:0]         pend_ch_q;
	logic [TICK_WIDTH-1:0]   tick_q;
	logic [NUM_CHANNELS-1:0] reg_q;
	logic [NUM_CHANNELS-1:0] run_q;
	mctb_pkg::out_item_t     out_q;
	logic                    out_vld_q;

	logic                    rd_en;
	logic [CH_W-1:0]         rd_addr;
	logic [EW-1:0]           rd_data;
	logic                    wr_en;
	logic [CH_W-1:0]         wr_addr;
	entry_t                  wr_ent;

	entry_t                  rd;
	logic                    accept;
	logic                    out_free;
	logic                    ch_ok;
	logic [CH_W-1:0]         ch_idx;
	logic                    ivl_fits;
	logic                    live;
	logic [TICK_WIDTH-1:0]   delta;
	logic                    fire;
	logic [31:0]             reps_dec;
	logic [TICK_WIDTH-1:0]   stamp_adv;
	entry_t                  scan_ent;
	logic                    scan_run;
	logic                    scan_go;
	logic                    scan_last;
	logic [NUM_CHANNELS-1:0] reg_d;
	logic [NUM_CHANNELS-1:0] run_d;
	logic [TICK_WIDTH-1:0]   tick_d;
	logic                    load_out;
	mctb_pkg::out_item_t     out_d;

	mctb_chan_mem #(
		.DEPTH (NUM_CHANNELS),
		.AW    (CH_W),
		.DW    (EW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_ent)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_vld_q || out_ready;
	assign out_valid = out_vld_q;
	assign out_item  = out_q;

	assign rd       = entry_t'(rd_data);
	assign ch_ok    = 32'(req_q.channel) < 32'(NUM_CHANNELS);
	assign ch_idx   = CH_W'(req_q.channel);
	assign ivl_fits = (64'(req_q.interval) >> TICK_WIDTH) == 64'd0;

	// poll evaluation of the entry read for idx_q
	assign live      = reg_q[idx_q] && run_q[idx_q];
	assign delta     = tick_q - rd.stamp;
	assign fire      = live && (delta >= rd.ivl);
	assign reps_dec  = rd.reps - 32'd1;
	assign stamp_adv = rd.stamp + rd.ivl;
	assign scan_go   = !(fire && pend_vld_q && !out_free);
	assign scan_last = (idx_q == CH_W'(NUM_CHANNELS - 1));

	always_comb begin
		scan_ent = rd;
		scan_run = 1'b1;
		case (rd.mode)
			mctb_pkg::MODE_ONCE: begin
				scan_run = 1'b0;
			end
			mctb_pkg::MODE_COUNTED: begin
				scan_ent.reps = reps_dec;
				if (reps_dec != 32'd0) begin
					scan_ent.stamp = stamp_adv;
				end else begin
					scan_run = 1'b0;
				end
			end
			mctb_pkg::MODE_FOREVER: begin
				scan_ent.stamp = stamp_adv;
			end
			default: begin
				// unknown mode keeps firing without re-arming
			end
		endcase
	end

	always_comb begin
		reg_d    = reg_q;
		run_d    = run_q;
		tick_d   = tick_q;
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_ent   = rd;
		load_out = 1'b0;
		out_d    = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rd_en = 1'b1;
					if (in_item.action != mctb_pkg::ACT_POLL) begin
						rd_addr = CH_W'(in_item.channel);
					end
				end
			end
			ST_UPD: begin
				if (out_free) begin
					load_out = 1'b1;
					case (req_q.action)
						mctb_pkg::ACT_REGISTER: begin
							if (ch_ok && req_q.interval != 32'd0 && ivl_fits
								&& !reg_q[ch_idx]) begin
								out_d.ok     = 1'b1;
								wr_en        = 1'b1;
								wr_addr      = ch_idx;
								wr_ent.mode  = req_q.mode;
								wr_ent.reps  = req_q.repeat_count;
								wr_ent.ivl   = TICK_WIDTH'(req_q.interval);
								reg_d[ch_idx] = 1'b1;
								run_d[ch_idx] = 1'b0;
							end
						end
						mctb_pkg::ACT_REMOVE: begin
							if (ch_ok && reg_q[ch_idx]) begin
								out_d.ok     = 1'b1;
								reg_d[ch_idx] = 1'b0;
								run_d[ch_idx] = 1'b0;
							end
						end
						mctb_pkg::ACT_START, mctb_pkg::ACT_STOP: begin
							if (ch_ok) begin
								out_d.ok      = 1'b1;
								wr_en         = 1'b1;
								wr_addr       = ch_idx;
								wr_ent.stamp  = tick_q;
								run_d[ch_idx] = (req_q.action == mctb_pkg::ACT_START);
							end
						end
						mctb_pkg::ACT_TICK: begin
							out_d.ok = 1'b1;
							tick_d   = tick_q + TICK_WIDTH'(1);
						end
						default: begin
							out_d.ok = 1'b0;
						end
					endcase
					out_d.tick_count  = 32'(tick_d);
					out_d.last_of_run = 1'b1;
				end
			end
			ST_SCAN: begin
				if (scan_go) begin
					if (fire) begin
						wr_en        = 1'b1;
						wr_addr      = idx_q;
						wr_ent       = scan_ent;
						run_d[idx_q] = scan_run;
						// a newer firing exists, so the held one is not last
						if (pend_vld_q) begin
							load_out            = 1'b1;
							out_d.ok            = 1'b1;
							out_d.fired         = 1'b1;
							out_d.fired_channel = 4'(pend_ch_q);
							out_d.tick_count    = 32'(tick_q);
							out_d.last_of_run   = 1'b0;
						end
					end
					if (!scan_last) begin
						rd_en   = 1'b1;
						rd_addr = idx_q + CH_W'(1);
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					load_out            = 1'b1;
					out_d.ok            = 1'b1;
					out_d.fired         = pend_vld_q;
					out_d.fired_channel = pend_vld_q ? 4'(pend_ch_q) : 4'd0;
					out_d.tick_count    = 32'(tick_q);
					out_d.last_of_run   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_vld_q <= 1'b0;
			tick_q     <= '0;
			reg_q      <= '0;
			run_q      <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			reg_q  <= reg_d;
			run_q  <= run_d;
			tick_q <= tick_d;
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pend_vld_q <= 1'b0;
						state_q    <= (in_item.action == mctb_pkg::ACT_POLL) ? ST_SCAN : ST_UPD;
					end
				end
				ST_UPD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						if (fire) begin
							pend_vld_q <= 1'b1;
						end
						if (scan_last) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_item;
			idx_q <= '0;
		end else if (state_q == ST_SCAN && scan_go) begin
			if (fire) begin
				pend_ch_q <= idx_q;
			end
			if (!scan_last) begin
				idx_q <= idx_q + CH_W'(1);
			end
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

`ifndef SYNTHESIS
	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("write back and read hit the same channel entry");

	a_tick_only_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tick_q) |-> $past(state_q == ST_UPD))
		else $error("tick counter changed outside a single-channel update");

	a_pending_only_in_poll: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> (state_q == ST_SCAN || state_q == ST_FLUSH))
		else $error("held firing result outside a poll");
`endif

endmodule

@@ tb/sv/mctb_checker.sv @@
`timescale 1ns / 1ps
// result checker for the timer bank: watches the request and result channels,
// keeps its own channel table and compares every result. depends on mctb_pkg.
module mctb_checker #(
	parameter int NUM_CHANNELS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  mctb_pkg::in_item_t  in_item,
	input  logic                out_valid,
	input  logic                out_ready,
	input  mctb_pkg::out_item_t out_item,
	output int                  mismatch_count,
	output int                  outstanding
);

	logic [31:0]             tick_now;
	logic [NUM_CHANNELS-1:0] chan_reg;
	logic [NUM_CHANNELS-1:0] chan_run;
	logic [1:0]              chan_mode  [NUM_CHANNELS];
	logic [31:0]             chan_reps  [NUM_CHANNELS];
	logic [31:0]             chan_ivl   [NUM_CHANNELS];
	logic [31:0]             chan_stamp [NUM_CHANNELS];

	mctb_pkg::out_item_t expected_results[$];
	int                  bad_results;

	// applies one request to the table and queues the results it causes
	task automatic predict_request(input mctb_pkg::in_item_t req);
		mctb_pkg::out_item_t res;
		mctb_pkg::out_item_t prev;
		logic [31:0]         elapsed;
		logic                have_prev;
		logic                ch_ok;
		have_prev = 1'b0;
		prev      = '0;
		res       = '0;
		ch_ok     = int'(req.channel) < NUM_CHANNELS;
		if (req.action == mctb_pkg::ACT_POLL) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (chan_reg[i] && chan_run[i]) begin
					elapsed = tick_now - chan_stamp[i];
					if (elapsed >= chan_ivl[i]) begin
						case (chan_mode[i])
							mctb_pkg::MODE_ONCE: chan_run[i] = 1'b0;
							mctb_pkg::MODE_COUNTED: begin
								chan_reps[i] = chan_reps[i] - 32'd1;
								if (chan_reps[i] != 32'd0)
									chan_stamp[i] = chan_stamp[i] + chan_ivl[i];
								else
									chan_run[i] = 1'b0;
							end
							mctb_pkg::MODE_FOREVER: chan_stamp[i] = chan_stamp[i] + chan_ivl[i];
							default: ;
						endcase
						if (have_prev)
							expected_results.push_back(prev);
						prev.ok            = 1'b1;
						prev.fired         = 1'b1;
						prev.fired_channel = 4'(i);
						prev.tick_count    = tick_now;
						prev.last_of_run   = 1'b0;
						have_prev          = 1'b1;
					end
				end
			end
			if (have_prev) begin
				prev.last_of_run = 1'b1;
				expected_results.push_back(prev);
			end else begin
				res.ok          = 1'b1;
				res.tick_count  = tick_now;
				res.last_of_run = 1'b1;
				expected_results.push_back(res);
			end
		end else begin
			case (req.action)
				mctb_pkg::ACT_REGISTER: begin
					if (ch_ok && req.interval != 32'd0 && !chan_reg[req.channel]) begin
						chan_mode[req.channel] = req.mode;
						chan_reps[req.channel] = req.repeat_count;
						chan_ivl[req.channel]  = req.interval;
						chan_run[req.channel]  = 1'b0;
						chan_reg[req.channel]  = 1'b1;
						res.ok = 1'b1;
					end
				end
				mctb_pkg::ACT_REMOVE: begin
					if (ch_ok && chan_reg[req.channel]) begin
						chan_reg[req.channel] = 1'b0;
						chan_run[req.channel] = 1'b0;
						res.ok = 1'b1;
					end
				end
				mctb_pkg::ACT_START, mctb_pkg::ACT_STOP: begin
					if (ch_ok) begin
						chan_run[req.channel]   = (req.action == mctb_pkg::ACT_START);
						chan_stamp[req.channel] = tick_now;
						res.ok = 1'b1;
					end
				end
				mctb_pkg::ACT_TICK: begin
					tick_now = tick_now + 32'd1;
					res.ok = 1'b1;
				end
				default: ;
			endcase
			res.tick_count  = tick_now;
			res.last_of_run = 1'b1;
			expected_results.push_back(res);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_now = '0;
			chan_reg = '0;
			chan_run = '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				chan_mode[i]  = '0;
				chan_reps[i]  = '0;
				chan_ivl[i]   = '0;
				chan_stamp[i] = '0;
			end
			expected_results.delete();
			bad_results = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					bad_results++;
					if (bad_results <= 10)
						$display("%0t: unexpected result ok=%0d fired=%0d ch=%0d tick=%0h last=%0d",
							$realtime, out_item.ok, out_item.fired, out_item.fired_channel,
							out_item.tick_count, out_item.last_of_run);
				end else begin
					mctb_pkg::out_item_t want;
					want = expected_results.pop_front();
					if (out_item.ok !== want.ok || out_item.fired !== want.fired ||
					    out_item.fired_channel !== want.fired_channel ||
					    out_item.tick_count !== want.tick_count ||
					    out_item.last_of_run !== want.last_of_run) begin
						bad_results++;
						if (bad_results <= 10)
							$display("%0t: result mismatch exp ok=%0d fired=%0d ch=%0d tick=%0h last=%0d, got ok=%0d fired=%0d ch=%0d tick=%0h last=%0d",
								$realtime, want.ok, want.fired, want.fired_channel,
								want.tick_count, want.last_of_run, out_item.ok,
								out_item.fired, out_item.fired_channel,
								out_item.tick_count, out_item.last_of_run);
					end
				end
			end
			// a request never yields a result in the cycle it is taken
			if (in_valid && in_ready)
				predict_request(in_item);
		end
		mismatch_count <= bad_results;
		outstanding    <= expected_results.size();
	end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// testbench top for the timer bank: clock, reset, request stimulus, result
// back-pressure and verdict. depends on mctb_pkg, mctb_checker and the block.
module tb_top;

	localparam int NUM_RANDOM  = 155;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	localparam logic [1:0] MODE_SPARE   = 2'd3;
	localparam logic [2:0] ACT_SPARE_LO = 3'd6;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	mctb_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_ready;
	mctb_pkg::out_item_t out_item;

	int   mismatch_count;
	int   outstanding;
	int   accepted_reqs = 0;
	int   quiet_cycles  = 0;
	logic sender_steady = 1'b0;
	logic held_off      = 1'b0;

	multi_channel_soft_timer_bank_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	mctb_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_item        (in_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_item       (out_item),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			accepted_reqs <= accepted_reqs + 1;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic mctb_pkg::in_item_t make_req(input logic [2:0] action,
		input logic [3:0] channel, input logic [1:0] mode, input logic [31:0] reps,
		input logic [31:0] ivl);
		mctb_pkg::in_item_t r;
		r.action       = action;
		r.channel      = channel;
		r.mode         = mode;
		r.repeat_count = reps;
		r.interval     = ivl;
		return r;
	endfunction

	// mostly register/start/tick/poll on a few channels so timers really expire
	function automatic mctb_pkg::in_item_t random_request();
		mctb_pkg::in_item_t r;
		int                 pick;
		pick = $urandom_range(99);
		if (pick < 14)      r.action = mctb_pkg::ACT_REGISTER;
		else if (pick < 22) r.action = mctb_pkg::ACT_REMOVE;
		else if (pick < 34) r.action = mctb_pkg::ACT_START;
		else if (pick < 39) r.action = mctb_pkg::ACT_STOP;
		else if (pick < 70) r.action = mctb_pkg::ACT_TICK;
		else if (pick < 96) r.action = mctb_pkg::ACT_POLL;
		else                r.action = ($urandom_range(1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
		r.channel = ($urandom_range(99) < 70) ? 4'($urandom_range(5)) : 4'($urandom_range(15));
		pick = $urandom_range(99);
		if (pick < 30)      r.mode = mctb_pkg::MODE_ONCE;
		else if (pick < 60) r.mode = mctb_pkg::MODE_COUNTED;
		else if (pick < 92) r.mode = mctb_pkg::MODE_FOREVER;
		else                r.mode = MODE_SPARE;
		r.repeat_count = ($urandom_range(99) < 80) ? 32'($urandom_range(4)) : $urandom;
		pick = $urandom_range(99);
		if (pick < 85)      r.interval = 32'($urandom_range(1, 6));
		else if (pick < 92) r.interval = '0;
		else                r.interval = $urandom;
		return r;
	endfunction

	task automatic send_request(input mctb_pkg::in_item_t req);
		in_valid <= 1'b1;
		in_item  <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (!sender_steady && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// receiver: random back-pressure, one long hold-off, one steady stretch
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held_off && accepted_reqs >= 90) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else if (accepted_reqs >= 50 && accepted_reqs < 80) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 9);
			end
		end
	end

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_item  <= '0;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		// directed: empty poll, register failures, every mode, odd counts
		send_request(make_req(mctb_pkg::ACT_POLL, 4'd0, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_REGISTER, 4'd0, mctb_pkg::MODE_ONCE, '1, '0));
		send_request(make_req(mctb_pkg::ACT_REGISTER, 4'd0, mctb_pkg::MODE_ONCE, '1, 32'd1));
		send_request(make_req(mctb_pkg::ACT_REGISTER, 4'd0, mctb_pkg::MODE_FOREVER, '0, 32'd5));
		send_request(make_req(mctb_pkg::ACT_REGISTER, 4'd15, mctb_pkg::MODE_COUNTED, '0, 32'd2));
		send_request(make_req(mctb_pkg::ACT_REGISTER, 4'd7, MODE_SPARE, 32'd3, 32'd1));
		send_request(make_req(mctb_pkg::ACT_REGISTER, 4'd3, mctb_pkg::MODE_FOREVER, 32'd1, '1));
		send_request(make_req(mctb_pkg::ACT_REGISTER, 4'd12, mctb_pkg::MODE_COUNTED, 32'd2,
			32'd1));
		send_request(make_req(mctb_pkg::ACT_START, 4'd0, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_START, 4'd15, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_START, 4'd7, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_START, 4'd3, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_START, 4'd12, mctb_pkg::MODE_ONCE, '0, '0));
		// start and stop of an unregistered channel still succeed
		send_request(make_req(mctb_pkg::ACT_START, 4'd9, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_STOP, 4'd9, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_TICK, 4'd0, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_TICK, 4'd0, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_POLL, 4'd0, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_POLL, 4'd0, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_REMOVE, 4'd5, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_REMOVE, 4'd0, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(ACT_SPARE_LO, 4'd15, MODE_SPARE, '1, '1));
		send_request(make_req(ACT_SPARE_HI, 4'd15, MODE_SPARE, '1, '1));
		send_request(make_req(mctb_pkg::ACT_STOP, 4'd7, mctb_pkg::MODE_ONCE, '0, '0));
		send_request(make_req(mctb_pkg::ACT_POLL, 4'd15, MODE_SPARE, '1, '1));
		wait_results_drained();

		for (int i = 0; i < NUM_RANDOM; i++) begin
			sender_steady = (i >= 100 && i < 140);
			if (i == 150)
				wait_results_drained();
			send_request(random_request());
		end

		wait_results_drained();
		repeat (40)
			@(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
src/mctb_pkg.sv
src/mctb_chan_mem.sv
src/multi_channel_soft_timer_bank_top.sv
tb/sv/mctb_checker.sv
tb/sv/tb_top.sv
